// File: rtl/fhs_pkg.sv
// Shared constants, types and helpers of the fade-in / hold / fade-out sequencer.
package fhs_pkg;

	// Fixed-point and timing sizes.
	localparam int LEVEL_FRACTION_BITS = 10;
	localparam int TIME_BITS           = 16;
	localparam int ELAPSED_BITS        = TIME_BITS + 1;
	localparam int QUO_BITS            = LEVEL_FRACTION_BITS + 1;
	localparam int DIV_STEPS           = QUO_BITS;
	localparam int STEP_BITS           = $clog2(DIV_STEPS);

	// Port field widths.
	localparam int DELTA_W   = 10;
	localparam int LEVEL_W   = 11;
	localparam int PHASE_W   = 3;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int S_DATA_W  = 16;
	localparam int M_DATA_W  = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FADE_IN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT = 2'd2;

	// Input operation codes.
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_STOP = 1'b1;

	// Sequence phases.
	typedef enum logic [PHASE_W-1:0] {
		PH_START  = 3'd0,
		PH_START2 = 3'd1,
		PH_IN     = 3'd2,
		PH_HOLD   = 3'd3,
		PH_OUT    = 3'd4,
		PH_DONE   = 3'd5
	} fhs_phase_t;

	// Full level in quotient width.
	localparam logic [QUO_BITS-1:0] FULL_LEVEL = QUO_BITS'(1) << LEVEL_FRACTION_BITS;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic first;
		logic emit;
	} fhs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
	} fhs_status_t;

	// Fit a quotient into the level field, keeping its low bits.
	function automatic logic [LEVEL_W-1:0] fit_level(input logic [QUO_BITS-1:0] v);
		logic [LEVEL_W-1:0] r;
		r = '0;
		for (int i = 0; i < LEVEL_W; i++) begin
			if (i < QUO_BITS) begin
				r[i] = v[i];
			end
		end
		return r;
	endfunction

	// Keep the low time bits of a register write.
	function automatic logic [TIME_BITS-1:0] fit_time(input logic [CFG_W-1:0] v);
		logic [TIME_BITS-1:0] r;
		r = '0;
		for (int i = 0; i < TIME_BITS; i++) begin
			if (i < CFG_W) begin
				r[i] = v[i];
			end
		end
		return r;
	endfunction

endpackage

// File: rtl/fhs_ctrl.sv
// Controller state machine: accepts an item, sequences the divider, hands off the result.
module fhs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  fhs_pkg::fhs_status_t status,
	output fhs_pkg::fhs_cmd_t    cmd
);
	import fhs_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t                state_q;
	logic [STEP_BITS-1:0]  step_q;

	// Commands are combinational from the state, the step count and the handshake inputs.
	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		cmd.load  = (state_q == ST_IDLE) && s_tvalid;
		cmd.step  = (state_q == ST_DIV);
		cmd.first = (step_q == '0);
		cmd.emit  = (state_q == ST_EMIT) && status.out_free;
	end

	// State and divider step count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_DIV;
						step_q  <= '0;
					end
				end
				ST_DIV: begin
					if (step_q == STEP_BITS'(DIV_STEPS - 1)) begin
						state_q <= ST_EMIT;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/fhs_datapath.sv
// Datapath: configuration, sequence state, restoring divider and output register.
module fhs_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic [fhs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fhs_pkg::CFG_W-1:0]     cfg_data,
	input  logic                         in_op,
	input  logic [fhs_pkg::DELTA_W-1:0]   in_delta,
	input  fhs_pkg::fhs_cmd_t            cmd,
	output fhs_pkg::fhs_status_t         status,
	input  logic                         m_tready,
	output logic                         m_tvalid,
	output logic [fhs_pkg::M_DATA_W-1:0]  m_tdata,
	output logic                         m_tuser
);
	import fhs_pkg::*;

	typedef enum logic [1:0] {
		LVL_ZERO,
		LVL_FULL,
		LVL_DIV
	} lvl_kind_t;

	localparam logic [ELAPSED_BITS-1:0] ELAPSED_CAP = '1;

	// Configuration and sequence state.
	logic [TIME_BITS-1:0]    fade_in_q;
	logic [TIME_BITS-1:0]    hold_q;
	logic [TIME_BITS-1:0]    fade_out_q;
	fhs_phase_t              phase_q;
	logic [ELAPSED_BITS-1:0] elapsed_q;
	logic                    cancel_q;

	// Result held while the divider runs.
	logic                    res_valid_q;
	lvl_kind_t               res_kind_q;
	fhs_phase_t              res_phase_q;

	// Divider registers.
	logic [TIME_BITS-1:0]    rem_q;
	logic [TIME_BITS-1:0]    den_q;
	logic [QUO_BITS-1:0]     quo_q;

	// Output register.
	logic                    out_valid_q;
	logic [LEVEL_W-1:0]      out_level_q;
	logic                    out_lvalid_q;
	fhs_phase_t              out_phase_q;
	logic                    out_done_q;

	// Decision for the accepted item.
	fhs_phase_t              nxt_phase;
	logic [ELAPSED_BITS-1:0] nxt_elapsed;
	logic [ELAPSED_BITS:0]   sum_ext;
	logic [ELAPSED_BITS-1:0] sat_elapsed;
	logic [TIME_BITS-1:0]    hold_eff;
	logic                    dec_valid;
	lvl_kind_t               dec_kind;
	logic [TIME_BITS-1:0]    dec_num;
	logic [TIME_BITS-1:0]    dec_den;
	logic                    dec_cancel;

	// Divider step.
	logic [TIME_BITS:0]      trial;
	logic [TIME_BITS:0]      diff;
	logic                    ge;
	logic [LEVEL_W-1:0]      res_level;

	// Saturating elapsed-time advance.
	always_comb begin
		sum_ext     = {1'b0, elapsed_q} + (ELAPSED_BITS + 1)'(in_delta);
		sat_elapsed = sum_ext[ELAPSED_BITS] ? ELAPSED_CAP : sum_ext[ELAPSED_BITS-1:0];
		hold_eff    = cancel_q ? '0 : hold_q;
	end

	// Phase step for the item at the input.
	always_comb begin
		nxt_phase   = phase_q;
		nxt_elapsed = elapsed_q;
		dec_valid   = 1'b0;
		dec_kind    = LVL_ZERO;
		dec_num     = elapsed_q[TIME_BITS-1:0];
		dec_den     = fade_in_q;
		dec_cancel  = 1'b0;
		if (in_op == OP_STOP) begin
			dec_cancel = 1'b1;
		end else begin
			unique case (phase_q) inside
				PH_START, PH_START2: begin
					dec_valid   = (fade_in_q != '0);
					nxt_elapsed = '0;
					nxt_phase   = (phase_q == PH_START) ? PH_START2 : PH_IN;
				end
				PH_IN: begin
					dec_valid = 1'b1;
					if (elapsed_q < ELAPSED_BITS'(fade_in_q)) begin
						dec_kind    = LVL_DIV;
						nxt_elapsed = sat_elapsed;
					end else begin
						dec_kind    = LVL_FULL;
						nxt_elapsed = '0;
						nxt_phase   = PH_HOLD;
					end
				end
				PH_HOLD: begin
					if (elapsed_q < ELAPSED_BITS'(hold_eff)) begin
						nxt_elapsed = sat_elapsed;
					end else begin
						nxt_elapsed = '0;
						nxt_phase   = PH_OUT;
					end
				end
				PH_OUT: begin
					dec_valid = 1'b1;
					if (fade_out_q == '0) begin
						dec_kind    = LVL_FULL;
						nxt_elapsed = '0;
						nxt_phase   = PH_DONE;
					end else if (elapsed_q < ELAPSED_BITS'(fade_out_q)) begin
						dec_kind    = LVL_DIV;
						dec_num     = fade_out_q - elapsed_q[TIME_BITS-1:0];
						dec_den     = fade_out_q;
						nxt_elapsed = sat_elapsed;
					end else begin
						dec_kind    = LVL_ZERO;
						nxt_elapsed = '0;
						nxt_phase   = PH_DONE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Configuration writes and sequence state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_in_q  <= '0;
			hold_q     <= '0;
			fade_out_q <= '0;
			phase_q    <= PH_START;
			elapsed_q  <= '0;
			cancel_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_FADE_IN: fade_in_q <= fit_time(cfg_data);
					REG_HOLD: begin
						hold_q   <= fit_time(cfg_data);
						cancel_q <= 1'b0;
					end
					REG_FADE_OUT: fade_out_q <= fit_time(cfg_data);
					default: begin
					end
				endcase
			end
			if (cmd.load) begin
				phase_q   <= nxt_phase;
				elapsed_q <= nxt_elapsed;
				if (dec_cancel) begin
					cancel_q <= 1'b1;
				end
			end
		end
	end

	// One quotient bit per step; the first step compares without doubling.
	always_comb begin
		trial = cmd.first ? {1'b0, rem_q} : {rem_q, 1'b0};
		diff  = trial - {1'b0, den_q};
		ge    = (trial >= {1'b0, den_q});
	end

	// Pending result and divider.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_valid_q <= dec_valid;
			res_kind_q  <= dec_kind;
			res_phase_q <= nxt_phase;
			rem_q       <= dec_num;
			den_q       <= dec_den;
			quo_q       <= '0;
		end else if (cmd.step) begin
			rem_q <= ge ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
			quo_q <= {quo_q[QUO_BITS-2:0], ge};
		end
	end

	// Level chosen by the item's kind.
	always_comb begin
		case (res_kind_q)
			LVL_DIV:  res_level = fit_level(quo_q);
			LVL_FULL: res_level = fit_level(FULL_LEVEL);
			default:  res_level = '0;
		endcase
	end

	// Output register: holds a result until the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_lvalid_q <= res_valid_q;
			out_level_q  <= res_level;
			out_phase_q  <= res_phase_q;
			out_done_q   <= (res_phase_q >= PH_DONE);
		end
	end

	assign status.out_free = !out_valid_q || m_tready;
	assign m_tvalid        = out_valid_q;
	assign m_tuser         = out_lvalid_q;
	assign m_tdata         = M_DATA_W'({out_done_q, out_phase_q, out_level_q});

endmodule

// File: rtl/fade_in_hold_out_sequencer_top.sv
// Top level of the fade-in / hold / fade-out brightness envelope sequencer.
// Each input transaction runs eleven radix-2 restoring divider steps, then one output
// register load; a new item is taken only after that load, so a stalled output also
// holds off the input.
// Reset (arst_n low, asynchronous): configuration and elapsed time zero, phase start, output empty.
// The configuration port takes a write every cycle.
module fade_in_hold_out_sequencer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write channel.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fhs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fhs_pkg::CFG_W-1:0]     cfg_data,
	// Input stream.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [fhs_pkg::S_DATA_W-1:0]  s_tdata,   // [9:0] delta_ms, [15:10] zero
	input  logic                          s_tuser,   // [0] op
	// Output stream.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [fhs_pkg::M_DATA_W-1:0]  m_tdata,   // [10:0] level, [13:11] phase,
	                                                 // [14] done_res, [15] zero
	output logic                          m_tuser    // [0] level_valid
);
	import fhs_pkg::*;

	fhs_cmd_t    cmd;
	fhs_status_t status;

	assign cfg_ready = 1'b1;

	fhs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	fhs_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_op     (s_tuser),
		.in_delta  (s_tdata[DELTA_W-1:0]),
		.cmd       (cmd),
		.status    (status),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

// File: rtl/fhs_checker.sv
// Port-level assertions for the sequencer, bound to its top level.
module fhs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [fhs_pkg::M_DATA_W-1:0]  m_tdata,
	input logic                          m_tuser
);
	import fhs_pkg::*;

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed while stalled");

	// An item without a new level carries level zero.
	a_level_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[LEVEL_W-1:0] == '0)
		else $error("level nonzero without level_valid");

	// The done flag agrees with the reported phase.
	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[LEVEL_W+PHASE_W] == (m_tdata[LEVEL_W+PHASE_W-1:LEVEL_W] == PH_DONE))
		else $error("done flag disagrees with phase");

	// The block takes one item at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item accepted while busy");

endmodule

bind fade_in_hold_out_sequencer_top fhs_checker u_fhs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
